### sv/vt4_pkg.sv
// ----------------------------------------------------------------------------
// vt4_pkg
// Shared constants and types for the 4x4 vertex transform.
// ----------------------------------------------------------------------------
package vt4_pkg;

    localparam int NUM_LANES       = 4;
    localparam int SLOT_BITS       = 16;
    localparam int FRAC_SHIFT      = 12;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 64;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_0 = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_1 = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_2 = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_3 = 8'd3;

    localparam logic [CFG_DATA_WIDTH-1:0] ROW_0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [CFG_DATA_WIDTH-1:0] ROW_1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [CFG_DATA_WIDTH-1:0] ROW_2_RESET = 64'h0000_1000_0000_0000;
    localparam logic [CFG_DATA_WIDTH-1:0] ROW_3_RESET = 64'h1000_0000_0000_0000;

    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } vt4_lane_ctrl_t;

endpackage

### sv/vt4_lane.sv
// ----------------------------------------------------------------------------
// vt4_lane
// One matrix row: four registered products, then a registered rounded sum.
// ----------------------------------------------------------------------------
module vt4_lane #(
    parameter int DATA_WIDTH = 24,
    parameter int COEF_WIDTH = 16,
    parameter int SUM_WIDTH  = DATA_WIDTH + COEF_WIDTH + 2
) (
    input  logic                                          clk,
    input  vt4_pkg::vt4_lane_ctrl_t                       ctrl,
    input  logic [vt4_pkg::CFG_DATA_WIDTH-1:0]            row,
    input  logic [vt4_pkg::NUM_LANES*DATA_WIDTH-1:0]      vec,
    output logic signed [SUM_WIDTH-1:0]                   sum
);

    localparam int PROD_WIDTH = DATA_WIDTH + COEF_WIDTH;
    localparam logic signed [SUM_WIDTH-1:0] ROUND_ADD =
        SUM_WIDTH'(1) << (vt4_pkg::FRAC_SHIFT - 1);

    logic signed [COEF_WIDTH-1:0] coef [vt4_pkg::NUM_LANES];
    logic signed [DATA_WIDTH-1:0] elem [vt4_pkg::NUM_LANES];
    logic signed [PROD_WIDTH-1:0] prod_reg [vt4_pkg::NUM_LANES];
    logic signed [SUM_WIDTH-1:0]  sum_reg;
    logic signed [SUM_WIDTH-1:0]  sum_next;

    always_comb
    begin
        for (int j = 0; j < vt4_pkg::NUM_LANES; j++)
        begin
            coef[j] = signed'(row[vt4_pkg::SLOT_BITS*j +: COEF_WIDTH]);
            elem[j] = signed'(vec[DATA_WIDTH*j +: DATA_WIDTH]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_mul)
        begin
            for (int j = 0; j < vt4_pkg::NUM_LANES; j++)
            begin
                prod_reg[j] <= coef[j] * elem[j];
            end
        end
    end

    always_comb
    begin
        sum_next = ROUND_ADD;
        for (int j = 0; j < vt4_pkg::NUM_LANES; j++)
        begin
            sum_next = sum_next + SUM_WIDTH'(prod_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_sum)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

### sv/vt4_merge.sv
// ----------------------------------------------------------------------------
// vt4_merge
// Shift, saturate each lane sum and combine the clamp flags into one result.
// ----------------------------------------------------------------------------
module vt4_merge #(
    parameter int DATA_WIDTH = 24,
    parameter int SUM_WIDTH  = 42
) (
    input  logic                                      clk,
    input  logic                                      en,
    input  logic [vt4_pkg::NUM_LANES*SUM_WIDTH-1:0]   sums,
    output logic [vt4_pkg::NUM_LANES*DATA_WIDTH-1:0]  data,
    output logic                                      clamped
);

    localparam int RES_WIDTH = SUM_WIDTH - vt4_pkg::FRAC_SHIFT;

    logic [DATA_WIDTH-1:0]          sat  [vt4_pkg::NUM_LANES];
    logic [vt4_pkg::NUM_LANES-1:0]  clip;
    logic [vt4_pkg::NUM_LANES*DATA_WIDTH-1:0] data_reg;
    logic [vt4_pkg::NUM_LANES*DATA_WIDTH-1:0] data_next;
    logic                           clamped_reg;

    for (genvar i = 0; i < vt4_pkg::NUM_LANES; i++)
    begin : g_sat
        logic [RES_WIDTH-1:0] res;
        assign res = sums[SUM_WIDTH*i + vt4_pkg::FRAC_SHIFT +: RES_WIDTH];
        if (RES_WIDTH > DATA_WIDTH)
        begin : g_wide
            logic [RES_WIDTH-DATA_WIDTH:0] top;
            logic                          lane_clip;
            logic [DATA_WIDTH-1:0]         lane_sat;
            assign top       = res[RES_WIDTH-1:DATA_WIDTH-1];
            assign lane_clip = (top != '0) && (top != '1);
            always_comb
            begin
                if (!lane_clip)
                begin
                    lane_sat = res[DATA_WIDTH-1:0];
                end
                else if (res[RES_WIDTH-1])
                begin
                    lane_sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
                end
                else
                begin
                    lane_sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
                end
            end
            assign clip[i] = lane_clip;
            assign sat[i]  = lane_sat;
        end
        else
        begin : g_narrow
            assign clip[i] = 1'b0;
            assign sat[i]  = DATA_WIDTH'(signed'(res));
        end
        assign data_next[DATA_WIDTH*i +: DATA_WIDTH] = sat[i];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg    <= data_next;
            clamped_reg <= |clip;
        end
    end

    assign data    = data_reg;
    assign clamped = clamped_reg;

endmodule

### sv/vertex_transform_4x4_top.sv
// ----------------------------------------------------------------------------
// vertex_transform_4x4_top
// Pipeline: an input transfer passes the product, sum and merge registers in turn.
// Throughput: one vertex per cycle unless stalled; 4 row lanes x 4 multipliers.
// Reset: rst_n clears pipeline valid flags and loads the identity matrix.
// Stall: low m_tready holds full stages with no gap downstream; s_tready low only when full.
// ----------------------------------------------------------------------------
module vertex_transform_4x4_top #(
    parameter int DATA_WIDTH = 24,
    parameter int COEF_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [vt4_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [vt4_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // in_x, in_y, in_z, in_w from bit 0 up, zero padding to whole bytes
    input  logic [((vt4_pkg::NUM_LANES*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // out_x, out_y, out_z, out_w from bit 0 up, zero padding to whole bytes
    output logic [((vt4_pkg::NUM_LANES*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
    // clamped
    output logic                                   m_tuser
);

    localparam int VEC_WIDTH   = vt4_pkg::NUM_LANES * DATA_WIDTH;
    localparam int TDATA_WIDTH = ((VEC_WIDTH + 7) / 8) * 8;
    localparam int SUM_WIDTH   = DATA_WIDTH + COEF_WIDTH + 2;

    logic [vt4_pkg::CFG_DATA_WIDTH-1:0] row_reg [vt4_pkg::NUM_LANES];
    logic                               mul_valid_reg;
    logic                               sum_valid_reg;
    logic                               out_valid_reg;
    logic                               en_mul;
    logic                               en_sum;
    logic                               en_out;
    vt4_pkg::vt4_lane_ctrl_t            lane_ctrl;
    logic [vt4_pkg::NUM_LANES*SUM_WIDTH-1:0] sums;
    logic [VEC_WIDTH-1:0]               out_data;
    logic                               out_clamped;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= vt4_pkg::ROW_0_RESET;
            row_reg[1] <= vt4_pkg::ROW_1_RESET;
            row_reg[2] <= vt4_pkg::ROW_2_RESET;
            row_reg[3] <= vt4_pkg::ROW_3_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                vt4_pkg::REG_ROW_0: row_reg[0] <= cfg_data;
                vt4_pkg::REG_ROW_1: row_reg[1] <= cfg_data;
                vt4_pkg::REG_ROW_2: row_reg[2] <= cfg_data;
                vt4_pkg::REG_ROW_3: row_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // advance a stage when it is empty or the next one advances
    assign en_out   = !out_valid_reg || m_tready;
    assign en_sum   = !sum_valid_reg || en_out;
    assign en_mul   = !mul_valid_reg || en_sum;
    assign s_tready = en_mul;

    assign lane_ctrl.en_mul = en_mul;
    assign lane_ctrl.en_sum = en_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_mul)
            begin
                mul_valid_reg <= s_tvalid;
            end
            if (en_sum)
            begin
                sum_valid_reg <= mul_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= sum_valid_reg;
            end
        end
    end

    for (genvar i = 0; i < vt4_pkg::NUM_LANES; i++)
    begin : g_lane
        vt4_lane #(
            .DATA_WIDTH (DATA_WIDTH),
            .COEF_WIDTH (COEF_WIDTH),
            .SUM_WIDTH  (SUM_WIDTH)
        ) u_lane (
            .clk  (clk),
            .ctrl (lane_ctrl),
            .row  (row_reg[i]),
            .vec  (s_tdata[VEC_WIDTH-1:0]),
            .sum  (sums[SUM_WIDTH*i +: SUM_WIDTH])
        );
    end

    vt4_merge #(
        .DATA_WIDTH (DATA_WIDTH),
        .SUM_WIDTH  (SUM_WIDTH)
    ) u_merge (
        .clk     (clk),
        .en      (en_out),
        .sums    (sums),
        .data    (out_data),
        .clamped (out_clamped)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_WIDTH'(out_data);
    assign m_tuser  = out_clamped;

endmodule
